// File: sv/mcfds_pkg.sv
// Shared constants and types of the max-cost-first delay scheduler.
package mcfds_pkg;

    localparam int DEF_QUEUE_DEPTH = 1024;
    localparam int DEF_COST_BITS   = 24;

    localparam int ID_W    = 10;
    localparam int SLOT_W  = 11;
    localparam int HOLD_W  = 11;
    localparam int TOTAL_W = 48;

    localparam logic [SLOT_W-1:0]  SLOT_MAX  = {SLOT_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Slot-wide command broadcast to every cell.
    typedef struct packed {
        logic ins;
        logic rel;
    } t_cell_ctl;

    // Status a cell shows its neighbors.
    typedef struct packed {
        logic valid;
        logic gt;
    } t_cell_flags;

endpackage

// File: sv/mcfds_cell.sv
// One cell of the sorted queue: holds one waiting request and shifts with its neighbors.
module mcfds_cell
    import mcfds_pkg::*;
#(
    parameter int COST_BITS = DEF_COST_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cell_ctl            i_ctl,
    input  logic [COST_BITS-1:0] i_new_cost,
    input  logic [ID_W-1:0]      i_new_id,
    input  t_cell_flags          i_prev_flags,
    input  logic [COST_BITS-1:0] i_prev_cost,
    input  logic [ID_W-1:0]      i_prev_id,
    input  t_cell_flags          i_next_flags,
    input  logic [COST_BITS-1:0] i_next_cost,
    input  logic [ID_W-1:0]      i_next_id,
    output t_cell_flags          o_flags,
    output logic [COST_BITS-1:0] o_cost,
    output logic [ID_W-1:0]      o_id
);

    logic                 r_valid;
    logic [COST_BITS-1:0] r_cost;
    logic [ID_W-1:0]      r_id;
    logic                 n_valid;
    logic [COST_BITS-1:0] n_cost;
    logic [ID_W-1:0]      n_id;
    logic                 w_gt;

    // The row is kept sorted by cost, highest first; among equal costs the
    // latest arrival sits first, so a new request goes ahead of equal costs.
    assign w_gt = r_valid && (r_cost > i_new_cost);

    always_comb begin
        n_valid = r_valid;
        n_cost  = r_cost;
        n_id    = r_id;
        priority if (i_ctl.ins && i_ctl.rel) begin
            if (i_next_flags.gt) begin
                n_valid = i_next_flags.valid;
                n_cost  = i_next_cost;
                n_id    = i_next_id;
            end else if (w_gt) begin
                n_valid = 1'b1;
                n_cost  = i_new_cost;
                n_id    = i_new_id;
            end
        end else if (i_ctl.ins) begin
            if (!w_gt) begin
                if (i_prev_flags.gt) begin
                    n_valid = 1'b1;
                    n_cost  = i_new_cost;
                    n_id    = i_new_id;
                end else begin
                    n_valid = i_prev_flags.valid;
                    n_cost  = i_prev_cost;
                    n_id    = i_prev_id;
                end
            end
        end else if (i_ctl.rel) begin
            n_valid = i_next_flags.valid;
            n_cost  = i_next_cost;
            n_id    = i_next_id;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cost <= n_cost;
        r_id   <= n_id;
    end

    assign o_flags.valid = r_valid;
    assign o_flags.gt    = w_gt;
    assign o_cost        = r_cost;
    assign o_id          = r_id;

endmodule

// File: sv/max_cost_first_delay_scheduler_core.sv
// Top level of the max-cost-first delay scheduler with its row of queue cells.
//
// Each input beat (i_start while o_busy is low) is one time slot. It may carry a
// new request (i_has_request, i_cost) that takes the next id. The waiting
// requests live in a row of QUEUE_DEPTH cells kept sorted by cost, so the
// highest-cost request is always in the first cell. Every slot all cells
// shift, insert or hold at once, so the block takes one slot per cycle and
// o_busy stays low.
// Exactly one result beat follows each slot, marked by o_done in the cycle after
// the slot was accepted. It carries the released request (if any), the slot
// number, the saturating running total and the overflow flag.
// The receiver cannot stall: each result is shown for a single cycle only.
// i_cfg_wr_en with i_cfg_wr_data sets hold_slots, the number of initial slots
// in which nothing is released; write it only while no slot is in flight.
// A synchronous reset (i_rst_n low) empties the queue and clears the counters,
// the running total and hold_slots. No clearing pass is needed.
module max_cost_first_delay_scheduler_core
    import mcfds_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int COST_BITS   = DEF_COST_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic                 i_has_request,
    input  logic [COST_BITS-1:0] i_cost,
    input  logic                 i_cfg_wr_en,
    input  logic [HOLD_W-1:0]    i_cfg_wr_data,
    output logic                 o_done,
    output logic                 o_release_valid,
    output logic [ID_W-1:0]      o_request_id,
    output logic [SLOT_W-1:0]    o_release_slot,
    output logic [TOTAL_W-1:0]   o_total_cost,
    output logic                 o_overflow
);

    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int PEND_W = COST_BITS + CNT_W;
    localparam int SUM_W  = ((PEND_W > TOTAL_W) ? PEND_W : TOTAL_W) + 1;

    logic [HOLD_W-1:0]  r_hold;
    logic [CNT_W-1:0]   r_count;
    logic [PEND_W-1:0]  r_pending;
    logic [TOTAL_W-1:0] r_total;
    logic [SLOT_W-1:0]  r_slot;
    logic [ID_W-1:0]    r_next_id;

    logic [CNT_W-1:0]   n_count;
    logic [PEND_W-1:0]  n_pending;
    logic [TOTAL_W-1:0] n_total;
    logic [SLOT_W-1:0]  n_slot;
    logic [ID_W-1:0]    n_next_id;

    logic                 w_accept;
    logic                 w_full;
    logic                 w_ins;
    logic                 w_rel;
    logic                 w_ovf;
    logic [SUM_W-1:0]     w_sum;
    logic [COST_BITS-1:0] w_head_cost;
    logic [ID_W-1:0]      w_head_id;
    t_cell_ctl            w_ctl;

    t_cell_flags          w_flags [QUEUE_DEPTH];
    logic [COST_BITS-1:0] w_cost  [QUEUE_DEPTH];
    logic [ID_W-1:0]      w_id    [QUEUE_DEPTH];

    logic                 r_done;
    logic                 r_rel_valid;
    logic [ID_W-1:0]      r_rel_id;
    logic [SLOT_W-1:0]    r_rel_slot;
    logic                 r_ovf;

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;
    assign w_full   = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_ins    = w_accept && i_has_request && !w_full;
    assign w_ovf    = w_accept && i_has_request && w_full;

    assign n_slot = (r_slot == SLOT_MAX) ? r_slot : r_slot + SLOT_W'(1);

    // After the insert the head is the new request when the first cell does not cost more.
    assign w_head_cost = (w_ins && !w_flags[0].gt) ? i_cost : w_cost[0];
    assign w_head_id   = (w_ins && !w_flags[0].gt) ? r_next_id : w_id[0];

    assign w_rel = w_accept && (n_slot > r_hold) && (w_ins || (r_count != '0));

    assign w_ctl.ins = w_ins;
    assign w_ctl.rel = w_rel;

    generate
        for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            t_cell_flags          w_pf;
            t_cell_flags          w_nf;
            logic [COST_BITS-1:0] w_pc;
            logic [COST_BITS-1:0] w_nc;
            logic [ID_W-1:0]      w_pi;
            logic [ID_W-1:0]      w_ni;

            if (g == 0) begin : g_first
                // The front of the row behaves as if an unbeatable entry sat before it.
                assign w_pf = '{valid: 1'b1, gt: 1'b1};
                assign w_pc = '0;
                assign w_pi = '0;
            end else begin : g_mid_prev
                assign w_pf = w_flags[g-1];
                assign w_pc = w_cost[g-1];
                assign w_pi = w_id[g-1];
            end

            if (g == QUEUE_DEPTH - 1) begin : g_last
                assign w_nf = '{valid: 1'b0, gt: 1'b0};
                assign w_nc = '0;
                assign w_ni = '0;
            end else begin : g_mid_next
                assign w_nf = w_flags[g+1];
                assign w_nc = w_cost[g+1];
                assign w_ni = w_id[g+1];
            end

            mcfds_cell #(
                .COST_BITS(COST_BITS)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_ctl),
                .i_new_cost  (i_cost),
                .i_new_id    (r_next_id),
                .i_prev_flags(w_pf),
                .i_prev_cost (w_pc),
                .i_prev_id   (w_pi),
                .i_next_flags(w_nf),
                .i_next_cost (w_nc),
                .i_next_id   (w_ni),
                .o_flags     (w_flags[g]),
                .o_cost      (w_cost[g]),
                .o_id        (w_id[g])
            );
        end
    endgenerate

    // The total is charged with the requests that waited before this slot.
    assign w_sum   = SUM_W'(r_total) + SUM_W'(r_pending);
    assign n_total = (w_sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : w_sum[TOTAL_W-1:0];

    assign n_pending = r_pending
                     + (w_ins ? PEND_W'(i_cost) : '0)
                     - (w_rel ? PEND_W'(w_head_cost) : '0);
    assign n_count   = r_count + CNT_W'(w_ins) - CNT_W'(w_rel);
    assign n_next_id = r_next_id + ID_W'(w_ins);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold    <= '0;
            r_count   <= '0;
            r_pending <= '0;
            r_total   <= '0;
            r_slot    <= '0;
            r_next_id <= '0;
            r_done    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_hold <= i_cfg_wr_data;
            end
            r_done <= w_accept;
            if (w_accept) begin
                r_count   <= n_count;
                r_pending <= n_pending;
                r_total   <= n_total;
                r_slot    <= n_slot;
                r_next_id <= n_next_id;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rel_valid <= w_rel;
            r_rel_id    <= w_rel ? w_head_id : '0;
            r_rel_slot  <= w_rel ? n_slot : '0;
            r_ovf       <= w_ovf;
        end
    end

    assign o_done          = r_done;
    assign o_release_valid = r_rel_valid;
    assign o_request_id    = r_rel_id;
    assign o_release_slot  = r_rel_slot;
    assign o_total_cost    = r_total;
    assign o_overflow      = r_ovf;

endmodule
